### rtl/qrv_pkg.sv
package qrv_pkg;

   // Default widths of the coefficient inputs and of the result fraction.
   localparam int IN_WIDTH_DEFAULT = 16;
   localparam int OUT_FRAC_DEFAULT = 16;

   // The coefficients are Q.8, whatever their total width.
   localparam int IN_FRAC_BITS = 8;

   // Every numeric result is a 32-bit two's complement word.
   localparam int OUT_WIDTH = 32;

   // One quotient bit beyond the result width is enough to detect clipping.
   localparam int QUOT_BITS = OUT_WIDTH + 1;

   typedef enum logic [1:0] {
      RK_NONE = 2'd0,
      RK_ONE  = 2'd1,
      RK_TWO  = 2'd2,
      RK_INF  = 2'd3
   } root_kind_type;

   typedef enum logic [1:0] {
      VK_NONE = 2'd0,
      VK_MIN  = 2'd1,
      VK_MAX  = 2'd2
   } vertex_kind_type;

endpackage

### rtl/quadratic_root_and_vertex_top.sv
// The result strobe rises once a beat has passed the input register, the split, product and
// discriminant stages, the one-digit-per-stage square root (IN_WIDTH + OUT_FRAC_BITS + 1
// stages), the operand stage, the 33-stage restoring dividers and the output register.
// Throughput: one beat per cycle; busy stays low and the result strobe cannot be held off.
// Reset is synchronous and active high; it clears only the valid pipeline, so no beat
// in flight at reset is ever delivered.
module quadratic_root_and_vertex_top #(
   parameter int IN_WIDTH      = qrv_pkg::IN_WIDTH_DEFAULT,
   parameter int OUT_FRAC_BITS = qrv_pkg::OUT_FRAC_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [IN_WIDTH-1:0]            req_coef_const,
   input  logic signed [IN_WIDTH-1:0]            req_coef_linear,
   input  logic signed [IN_WIDTH-1:0]            req_coef_square,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_root_kind,
   output logic signed [qrv_pkg::OUT_WIDTH-1:0]  rsp_root_first,
   output logic signed [qrv_pkg::OUT_WIDTH-1:0]  rsp_root_second,
   output logic [1:0]                            rsp_vertex_kind,
   output logic signed [qrv_pkg::OUT_WIDTH-1:0]  rsp_vertex_x,
   output logic signed [qrv_pkg::OUT_WIDTH-1:0]  rsp_vertex_y,
   output logic                                  rsp_saturated
);
   import qrv_pkg::*;

   localparam int W = IN_WIDTH;
   localparam int F = OUT_FRAC_BITS;

   // The discriminant magnitude is below 2^(2W+1).
   localparam int D_W   = 2 * W + 1;
   // The square root works on D scaled by 2^(2F), so the root carries F fraction bits.
   localparam int RAD_W = D_W + 2 * F;
   localparam int S_W   = (RAD_W + 1) / 2;
   // |b| scaled to F fraction bits, and the magnitude of -b +/- sqrt(D).
   localparam int NB_W  = W + F;
   localparam int N_W   = ((NB_W > S_W) ? NB_W : S_W) + 1;

   // Dividend widths include one bit for the rounding half-divisor.
   localparam int VX_NUM_W = NB_W + 1;
   localparam int VX_DEN_W = W + 1;
   localparam int VY_NUM_W = D_W + F + 1;
   localparam int VY_DEN_W = W + IN_FRAC_BITS + 2;
   localparam int RT_NUM_W = N_W + 1;
   localparam int RT_DEN_W = W + 1;

   localparam int DIV_LAT = QUOT_BITS + 2;
   localparam int LAT     = 4 + S_W + 1 + DIV_LAT + 1;

   typedef struct packed {
      logic         a_neg;
      logic         a_zero;
      logic         b_neg;
      logic         b_zero;
      logic         c_neg;
      logic         c_zero;
      logic [W-1:0] am;
      logic [W-1:0] bm;
      logic [W-1:0] cm;
   } coef_type;

   typedef struct packed {
      coef_type       cf;
      logic [D_W-1:0] dm;
      logic           dneg;
      logic           dz;
   } side_type;

   // Only the case flags are needed once the dividers have their operands.
   typedef struct packed {
      logic a_zero;
      logic b_zero;
      logic c_zero;
      logic c_neg;
      logic dneg;
      logic dz;
   } flag_type;

   // The pipeline never stalls, so every start is taken.
   assign busy = 1'b0;

   // Valid bits travel alongside the data, one per register stage.
   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // Stage 1: capture the coefficients.
   logic signed [W-1:0] a_ff, b_ff, c_ff;

   always_ff @(posedge clock) begin
      a_ff <= req_coef_const;
      b_ff <= req_coef_linear;
      c_ff <= req_coef_square;
   end

   // Stage 2: split each coefficient into sign, zero flag and magnitude. The magnitude
   // of the most negative value still fits as an unsigned W-bit number.
   coef_type cf2_in, cf2_ff;

   always_comb begin
      cf2_in.a_neg  = a_ff[W-1];
      cf2_in.a_zero = (a_ff == '0);
      cf2_in.b_neg  = b_ff[W-1];
      cf2_in.b_zero = (b_ff == '0);
      cf2_in.c_neg  = c_ff[W-1];
      cf2_in.c_zero = (c_ff == '0);
      cf2_in.am     = a_ff[W-1] ? W'(~a_ff + 1'b1) : W'(a_ff);
      cf2_in.bm     = b_ff[W-1] ? W'(~b_ff + 1'b1) : W'(b_ff);
      cf2_in.cm     = c_ff[W-1] ? W'(~c_ff + 1'b1) : W'(c_ff);
   end

   always_ff @(posedge clock) begin
      cf2_ff <= cf2_in;
   end

   // Stage 3: the two products of the discriminant, on magnitudes.
   logic [2*W-1:0] b2_in, b2_ff;
   logic [2*W-1:0] ac_in, ac_ff;
   coef_type       cf3_ff;

   assign b2_in = cf2_ff.bm * cf2_ff.bm;
   assign ac_in = cf2_ff.am * cf2_ff.cm;

   always_ff @(posedge clock) begin
      b2_ff  <= b2_in;
      ac_ff  <= ac_in;
      cf3_ff <= cf2_ff;
   end

   // Stage 4: D = b*b - 4*a*c as sign and magnitude. The 4ac term only subtracts when
   // a and c are both nonzero and share a sign.
   side_type       s4_in, s4_ff;
   logic [D_W-1:0] b2x, ac4;
   logic           same_sign;

   always_comb begin
      b2x       = D_W'(b2_ff);
      ac4       = D_W'({ac_ff, 2'b00});
      same_sign = !cf3_ff.a_zero && !cf3_ff.c_zero && (cf3_ff.a_neg == cf3_ff.c_neg);
      s4_in.cf  = cf3_ff;
      if (same_sign) begin
         if (b2x >= ac4) begin
            s4_in.dm   = b2x - ac4;
            s4_in.dneg = 1'b0;
         end else begin
            s4_in.dm   = ac4 - b2x;
            s4_in.dneg = 1'b1;
         end
      end else begin
         s4_in.dm   = b2x + ac4;
         s4_in.dneg = 1'b0;
      end
      s4_in.dz = (s4_in.dm == '0);
   end

   always_ff @(posedge clock) begin
      s4_ff <= s4_in;
   end

   // Square root of D with F fraction bits, truncated. The side data rides a shift line
   // of the same depth so it lines up with the root.
   logic [S_W-1:0] sqrt_root;
   side_type       sd_ff [0:S_W-1];

   qrv_sqrt #(
      .X_W (RAD_W)
   ) u_sqrt (
      .clock (clock),
      .rad   ({s4_ff.dm, {(2*F){1'b0}}}),
      .root  (sqrt_root)
   );

   always_ff @(posedge clock) begin
      sd_ff[0] <= s4_ff;
      for (int k = 1; k < S_W; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
   end

   // Operand stage: each quotient is formed as (|num| + den/2) / den with a separate
   // sign, which gives round to nearest with ties away from zero.
   side_type              sd;
   logic [NB_W-1:0]       nbm;
   logic signed [N_W:0]   negb_s, s_s, n1, n2;
   logic [N_W-1:0]        n1m, n2m;

   logic [VX_NUM_W-1:0]   vx_num_in, vx_num_ff;
   logic [VX_DEN_W-1:0]   vx_den_in, vx_den_ff;
   logic                  vx_neg_in, vx_neg_ff;
   logic [VY_NUM_W-1:0]   vy_num_in, vy_num_ff;
   logic [VY_DEN_W-1:0]   vy_den_in, vy_den_ff;
   logic                  vy_neg_in, vy_neg_ff;
   logic [RT_NUM_W-1:0]   r1_num_in, r1_num_ff;
   logic [RT_DEN_W-1:0]   r1_den_in, r1_den_ff;
   logic                  r1_neg_in, r1_neg_ff;
   logic [RT_NUM_W-1:0]   r2_num_in, r2_num_ff;
   logic [RT_DEN_W-1:0]   r2_den_in, r2_den_ff;
   logic                  r2_neg_in, r2_neg_ff;
   flag_type              pf_in, pf_ff;

   always_comb begin
      sd     = sd_ff[S_W-1];
      nbm    = NB_W'(sd.cf.bm) << F;
      // -b is positive exactly when b is negative.
      negb_s = sd.cf.b_neg ? signed'((N_W + 1)'(nbm)) : -signed'((N_W + 1)'(nbm));
      s_s    = signed'((N_W + 1)'(sqrt_root));
      n1     = negb_s + s_s;
      n2     = negb_s - s_s;
      n1m    = n1[N_W] ? N_W'(-n1) : N_W'(n1);
      n2m    = n2[N_W] ? N_W'(-n2) : N_W'(n2);

      // Vertex abscissa -b / 2c.
      vx_den_in = VX_DEN_W'({sd.cf.cm, 1'b0});
      vx_num_in = VX_NUM_W'(nbm) + VX_NUM_W'(sd.cf.cm);
      vx_neg_in = (!sd.cf.b_neg && !sd.cf.b_zero) ^ sd.cf.c_neg;

      // Vertex ordinate -D / 4c, with c carrying its own 8 fraction bits.
      vy_den_in = {sd.cf.cm, {(IN_FRAC_BITS + 2){1'b0}}};
      vy_num_in = VY_NUM_W'({sd.dm, {F{1'b0}}}) + VY_NUM_W'(vy_den_in >> 1);
      vy_neg_in = !sd.dz && (sd.dneg == sd.cf.c_neg);

      // First root: -a / b for a linear polynomial, else (-b + sqrt D) / 2c. With a zero
      // discriminant the latter is the vertex abscissa itself.
      if (sd.cf.c_zero) begin
         r1_den_in = RT_DEN_W'(sd.cf.bm);
         r1_num_in = (RT_NUM_W'(sd.cf.am) << F) + RT_NUM_W'(sd.cf.bm >> 1);
         r1_neg_in = (!sd.cf.a_neg && !sd.cf.a_zero) ^ sd.cf.b_neg;
      end else begin
         r1_den_in = RT_DEN_W'({sd.cf.cm, 1'b0});
         r1_num_in = RT_NUM_W'(n1m) + RT_NUM_W'(sd.cf.cm);
         r1_neg_in = n1[N_W] ^ sd.cf.c_neg;
      end

      // Second root (-b - sqrt D) / 2c.
      r2_den_in = RT_DEN_W'({sd.cf.cm, 1'b0});
      r2_num_in = RT_NUM_W'(n2m) + RT_NUM_W'(sd.cf.cm);
      r2_neg_in = n2[N_W] ^ sd.cf.c_neg;

      pf_in.a_zero = sd.cf.a_zero;
      pf_in.b_zero = sd.cf.b_zero;
      pf_in.c_zero = sd.cf.c_zero;
      pf_in.c_neg  = sd.cf.c_neg;
      pf_in.dneg   = sd.dneg;
      pf_in.dz     = sd.dz;
   end

   always_ff @(posedge clock) begin
      vx_num_ff <= vx_num_in;
      vx_den_ff <= vx_den_in;
      vx_neg_ff <= vx_neg_in;
      vy_num_ff <= vy_num_in;
      vy_den_ff <= vy_den_in;
      vy_neg_ff <= vy_neg_in;
      r1_num_ff <= r1_num_in;
      r1_den_ff <= r1_den_in;
      r1_neg_ff <= r1_neg_in;
      r2_num_ff <= r2_num_in;
      r2_den_ff <= r2_den_in;
      r2_neg_ff <= r2_neg_in;
      pf_ff     <= pf_in;
   end

   // Four dividers run side by side. A divider whose divisor is zero in some case
   // produces garbage there, but its result and flag are dropped for that case below.
   logic [OUT_WIDTH-1:0] vx_q, vy_q, r1_q, r2_q;
   logic                 vx_sat, vy_sat, r1_sat, r2_sat;

   qrv_div #(.NUM_W (VX_NUM_W), .DEN_W (VX_DEN_W)) u_div_vx (
      .clock (clock), .num (vx_num_ff), .den (vx_den_ff), .neg (vx_neg_ff),
      .quot  (vx_q),  .sat (vx_sat)
   );

   qrv_div #(.NUM_W (VY_NUM_W), .DEN_W (VY_DEN_W)) u_div_vy (
      .clock (clock), .num (vy_num_ff), .den (vy_den_ff), .neg (vy_neg_ff),
      .quot  (vy_q),  .sat (vy_sat)
   );

   qrv_div #(.NUM_W (RT_NUM_W), .DEN_W (RT_DEN_W)) u_div_r1 (
      .clock (clock), .num (r1_num_ff), .den (r1_den_ff), .neg (r1_neg_ff),
      .quot  (r1_q),  .sat (r1_sat)
   );

   qrv_div #(.NUM_W (RT_NUM_W), .DEN_W (RT_DEN_W)) u_div_r2 (
      .clock (clock), .num (r2_num_ff), .den (r2_den_ff), .neg (r2_neg_ff),
      .quot  (r2_q),  .sat (r2_sat)
   );

   flag_type fd_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      fd_ff[0] <= pf_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         fd_ff[k] <= fd_ff[k-1];
      end
   end

   // Output stage: pick the fields for the case at hand and zero everything unused.
   flag_type             fl;
   root_kind_type        rk_in, rk_ff;
   vertex_kind_type      vk_in, vk_ff;
   logic [OUT_WIDTH-1:0] r1_in, r1_ff, r2_in, r2_ff, vx_in, vx_ff, vy_in, vy_ff;
   logic                 sat_in, sat_ff;

   always_comb begin
      fl     = fd_ff[DIV_LAT-1];
      rk_in  = RK_NONE;
      vk_in  = VK_NONE;
      r1_in  = '0;
      r2_in  = '0;
      vx_in  = '0;
      vy_in  = '0;
      sat_in = 1'b0;
      if (fl.c_zero) begin
         if (fl.b_zero) begin
            rk_in = fl.a_zero ? RK_INF : RK_NONE;
         end else begin
            rk_in  = RK_ONE;
            r1_in  = r1_q;
            sat_in = r1_sat;
         end
      end else begin
         vk_in  = fl.c_neg ? VK_MAX : VK_MIN;
         vx_in  = vx_q;
         vy_in  = vy_q;
         sat_in = vx_sat | vy_sat;
         if (fl.dneg) begin
            rk_in = RK_NONE;
         end else if (fl.dz) begin
            rk_in  = RK_ONE;
            r1_in  = r1_q;
            sat_in = sat_in | r1_sat;
         end else begin
            rk_in  = RK_TWO;
            r1_in  = r1_q;
            r2_in  = r2_q;
            sat_in = sat_in | r1_sat | r2_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      rk_ff  <= rk_in;
      vk_ff  <= vk_in;
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      sat_ff <= sat_in;
   end

   assign rsp_root_kind   = rk_ff;
   assign rsp_root_first  = r1_ff;
   assign rsp_root_second = r2_ff;
   assign rsp_vertex_kind = vk_ff;
   assign rsp_vertex_x    = vx_ff;
   assign rsp_vertex_y    = vy_ff;
   assign rsp_saturated   = sat_ff;

   // Every result beat answers exactly one accepted beat.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LAT))
      else $error("result beat without a matching accepted beat");

   // Infinitely many zeros only for the all-zero polynomial: nothing else is reported.
   a_all_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == RK_INF) |->
         (rsp_root_first == '0) && (rsp_root_second == '0) &&
         (rsp_vertex_kind == VK_NONE) && !rsp_saturated)
      else $error("degenerate polynomial reported with nonzero fields");

   // Without an extremum the vertex fields and the second root stay zero.
   a_no_vertex : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vertex_kind == VK_NONE) |->
         (rsp_vertex_x == '0) && (rsp_vertex_y == '0) && (rsp_root_second == '0))
      else $error("vertex fields set with no extremum");

   // No real zero means both root fields are zero.
   a_no_root : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == RK_NONE) |->
         (rsp_root_first == '0) && (rsp_root_second == '0))
      else $error("root fields set with no real zero");

endmodule

### rtl/qrv_sqrt.sv
module qrv_sqrt #(
   parameter int X_W = 65
) (
   input  logic                     clock,
   input  logic [X_W-1:0]           rad,
   output logic [(X_W+1)/2-1:0]     root
);
   localparam int R_W  = (X_W + 1) / 2;
   localparam int RM_W = R_W + 2;
   localparam int P_W  = 2 * R_W;

   // One result bit per stage; stage i holds the partial root after i+1 digits.
   logic [RM_W-1:0] rem_ff  [0:R_W-1];
   logic [R_W-1:0]  root_ff [0:R_W-1];
   logic [P_W-1:0]  rad_ff  [0:R_W-1];

   genvar i;
   for (i = 0; i < R_W; i++) begin : g_step
      logic [RM_W-1:0] rem_src;
      logic [R_W-1:0]  root_src;
      logic [P_W-1:0]  rad_src;
      logic [RM_W+1:0] cand;
      logic [RM_W+1:0] trial;
      logic [RM_W-1:0] rem_in;
      logic [R_W-1:0]  root_in;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = P_W'(rad);
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rad_src  = rad_ff[i-1];
      end

      always_comb begin
         cand  = {rem_src, rad_src[P_W-1 -: 2]};
         trial = (RM_W + 2)'({root_src, 2'b01});
         if (cand >= trial) begin
            rem_in  = RM_W'(cand - trial);
            root_in = {root_src[R_W-2:0], 1'b1};
         end else begin
            rem_in  = RM_W'(cand);
            root_in = {root_src[R_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         rad_ff[i]  <= {rad_src[P_W-3:0], 2'b00};
      end
   end

   assign root = root_ff[R_W-1];

endmodule

### rtl/qrv_div.sv
module qrv_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 17
) (
   input  logic                           clock,
   input  logic [NUM_W-1:0]               num,
   input  logic [DEN_W-1:0]               den,
   input  logic                           neg,
   output logic [qrv_pkg::OUT_WIDTH-1:0]  quot,
   output logic                           sat
);
   import qrv_pkg::*;

   localparam int QB    = QUOT_BITS;
   localparam int HI_W  = (NUM_W > QB) ? NUM_W - QB : 1;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam logic [QB-1:0] NEG_MAX = QB'(1) << (OUT_WIDTH - 1);
   localparam logic [QB-1:0] POS_MAX = NEG_MAX - QB'(1);

   logic [QB+HI_W-1:0] num_x;
   logic [HI_W-1:0]    hi;
   logic               over_in;

   // A quotient too wide for QB bits always clips, so it is caught up front.
   assign num_x   = (QB + HI_W)'(num);
   assign hi      = num_x[QB+HI_W-1:QB];
   assign over_in = CMP_W'(hi) >= CMP_W'(den);

   logic [DEN_W-1:0] rem_ff  [0:QB];
   logic [QB-1:0]    quo_ff  [0:QB];
   logic [QB-1:0]    low_ff  [0:QB];
   logic [DEN_W-1:0] den_ff  [0:QB];
   logic             neg_ff  [0:QB];
   logic             over_ff [0:QB];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= over_in ? '0 : DEN_W'(hi);
      quo_ff[0]  <= '0;
      low_ff[0]  <= num_x[QB-1:0];
      den_ff[0]  <= den;
      neg_ff[0]  <= neg;
      over_ff[0] <= over_in;
   end

   // Restoring division, one quotient bit per stage.
   genvar i;
   for (i = 0; i < QB; i++) begin : g_step
      logic [DEN_W:0] part;
      logic [DEN_W:0] diff;
      logic           ge;

      assign part = {rem_ff[i], low_ff[i][QB-1]};
      assign diff = part - {1'b0, den_ff[i]};
      assign ge   = part >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
         quo_ff[i+1]  <= {quo_ff[i][QB-2:0], ge};
         low_ff[i+1]  <= {low_ff[i][QB-2:0], 1'b0};
         den_ff[i+1]  <= den_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
         over_ff[i+1] <= over_ff[i];
      end
   end

   logic [QB-1:0]        q;
   logic [OUT_WIDTH-1:0] quot_in;
   logic                 sat_in;
   logic [OUT_WIDTH-1:0] quot_ff;
   logic                 sat_ff;

   assign q = quo_ff[QB];

   always_comb begin
      if (neg_ff[QB]) begin
         sat_in  = over_ff[QB] || (q > NEG_MAX);
         quot_in = sat_in ? NEG_MAX[OUT_WIDTH-1:0] : OUT_WIDTH'(QB'(0) - q);
      end else begin
         sat_in  = over_ff[QB] || (q > POS_MAX);
         quot_in = sat_in ? POS_MAX[OUT_WIDTH-1:0] : q[OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

### tb/quadratic_root_and_vertex_top_tb.sv
`timescale 1ns / 100ps

module quadratic_root_and_vertex_top_tb;
   import qrv_pkg::*;

   localparam int IN_W      = 16;
   localparam int FRAC_OUT  = 16;
   localparam int LATENCY   = IN_W + FRAC_OUT + 42;
   localparam int CYCLE_CAP = 600000;

   // One polynomial to be sent, with the idle time the sender spends before it.
   // When drain is set, the sender also waits until every result has come back.
   typedef struct {
      logic signed [IN_W-1:0] a;
      logic signed [IN_W-1:0] b;
      logic signed [IN_W-1:0] c;
      int unsigned            gap;
      bit                     drain;
   } poly_beat_type;

   // What the block should report for one polynomial.
   typedef struct {
      root_kind_type          rk;
      logic signed [31:0]     r1;
      logic signed [31:0]     r2;
      vertex_kind_type        vk;
      logic signed [31:0]     vx;
      logic signed [31:0]     vy;
      logic                   sat;
   } roots_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic signed [IN_W-1:0] req_coef_const;
   logic signed [IN_W-1:0] req_coef_linear;
   logic signed [IN_W-1:0] req_coef_square;
   logic                   rsp_valid;
   logic [1:0]             rsp_root_kind;
   logic signed [31:0]     rsp_root_first;
   logic signed [31:0]     rsp_root_second;
   logic [1:0]             rsp_vertex_kind;
   logic signed [31:0]     rsp_vertex_x;
   logic signed [31:0]     rsp_vertex_y;
   logic                   rsp_saturated;

   poly_beat_type poly_queue[$];
   roots_type     roots_due[$];
   int unsigned gap_left;
   int unsigned errors;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned two_root_count;
   int unsigned sat_count;
   int unsigned cycle_count;
   bit          stim_done;

   quadratic_root_and_vertex_top #(
      .IN_WIDTH(IN_W),
      .OUT_FRAC_BITS(FRAC_OUT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_coef_const(req_coef_const),
      .req_coef_linear(req_coef_linear),
      .req_coef_square(req_coef_square),
      .rsp_valid(rsp_valid),
      .rsp_root_kind(rsp_root_kind),
      .rsp_root_first(rsp_root_first),
      .rsp_root_second(rsp_root_second),
      .rsp_vertex_kind(rsp_vertex_kind),
      .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y),
      .rsp_saturated(rsp_saturated)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Magnitude of a signed value as an unsigned 64-bit number.
   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Floor of the square root of a 128-bit value, one result bit per step.
   function automatic logic [63:0] floor_sqrt(logic [127:0] x);
      logic [127:0] res;
      logic [127:0] bitv;
      logic [127:0] t;
      res  = '0;
      bitv = 128'd1 << 126;
      while (bitv != 0 && bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (x >= t) begin
            x   = x - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[63:0];
   endfunction

   // Quotient rounded to nearest with ties away from zero, then clipped to
   // the 32-bit result range. Clipping raises the saturation flag.
   function automatic logic [31:0] round_clip_div(logic [127:0] num, logic [63:0] den,
                                                  bit neg, inout logic sat);
      logic [127:0] q;
      q = (num + {64'd0, den >> 1}) / {64'd0, den};
      if (neg) begin
         if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return 32'(-q[31:0]);
      end
      if (q > 128'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   function automatic logic [31:0] signed_div(longint n, longint d, inout logic sat);
      return round_clip_div({64'd0, magnitude(n)}, magnitude(d), (n < 0) != (d < 0), sat);
   endfunction

   // Zeros and vertex of a + b*x + c*x^2. The discriminant is kept as a
   // magnitude with a separate sign so that it stays exact at every width.
   function automatic roots_type solve_poly(logic signed [IN_W-1:0] a_in,
                                            logic signed [IN_W-1:0] b_in,
                                            logic signed [IN_W-1:0] c_in);
      roots_type    r;
      longint       a;
      longint       b;
      longint       c;
      logic [63:0]  am;
      logic [63:0]  bm;
      logic [63:0]  cm;
      logic [127:0] b2;
      logic [127:0] ac4;
      logic [127:0] dm;
      bit           dneg;
      bit           dz;
      longint       negb;
      longint       neg_a;
      longint       s;
      a  = a_in;
      b  = b_in;
      c  = c_in;
      am = magnitude(a);
      bm = magnitude(b);
      cm = magnitude(c);
      r  = '{rk: RK_NONE, vk: VK_NONE, default: '0};
      b2   = {64'd0, bm * bm};
      ac4  = {64'd0, am * cm} << 2;
      dneg = 1'b0;
      if (a != 0 && c != 0 && ((a < 0) == (c < 0))) begin
         if (b2 >= ac4) begin
            dm = b2 - ac4;
         end else begin
            dm   = ac4 - b2;
            dneg = 1'b1;
         end
      end else begin
         dm = b2 + ac4;
      end
      dz   = (dm == 0);
      negb = (b < 0) ? longint'(bm << FRAC_OUT) : -longint'(bm << FRAC_OUT);

      if (c == 0) begin
         if (b == 0) begin
            r.rk = (a == 0) ? RK_INF : RK_NONE;
         end else begin
            neg_a = (a < 0) ? longint'(am << FRAC_OUT) : -longint'(am << FRAC_OUT);
            r.rk  = RK_ONE;
            r.r1  = signed_div(neg_a, b, r.sat);
         end
      end else begin
         r.vk = (c > 0) ? VK_MIN : VK_MAX;
         r.vx = signed_div(negb, 2 * c, r.sat);
         // The vertex value is -D/(4c); its sign follows from the signs of D and c.
         r.vy = round_clip_div(dm << FRAC_OUT, cm << (IN_FRAC_BITS + 2),
                               !dz && (dneg == (c < 0)), r.sat);
         if (dneg) begin
            r.rk = RK_NONE;
         end else if (dz) begin
            r.rk = RK_ONE;
            r.r1 = r.vx;
         end else begin
            s    = longint'(floor_sqrt(dm << (2 * FRAC_OUT)));
            r.rk = RK_TWO;
            r.r1 = signed_div(negb + s, 2 * c, r.sat);
            r.r2 = signed_div(negb - s, 2 * c, r.sat);
         end
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one, and long runs with none at all.
   function automatic int unsigned pick_gap(bit burst);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_poly(int a, int b, int c, int unsigned gap, bit drain);
      poly_beat_type p;
      p.a     = IN_W'(a);
      p.b     = IN_W'(b);
      p.c     = IN_W'(c);
      p.gap   = gap;
      p.drain = drain;
      poly_queue.push_back(p);
   endtask

   // Driver. A beat is taken at the edge where start is high and busy is low;
   // at that edge the expectation for it is recorded. Start is assigned at
   // most once per edge, so a back-to-back beat keeps it high throughout.
   always @(posedge clock) begin
      if (reset) begin
         start           <= 1'b0;
         req_coef_const  <= '0;
         req_coef_linear <= '0;
         req_coef_square <= '0;
         gap_left        = 0;
      end else begin
         if (start && !busy) begin
            roots_due.push_back(solve_poly(req_coef_const, req_coef_linear, req_coef_square));
            sent_count++;
         end
         if (!start || !busy) begin
            if (poly_queue.size() == 0) begin
               start <= 1'b0;
            end else if (gap_left < poly_queue[0].gap) begin
               gap_left++;
               start <= 1'b0;
            end else if (poly_queue[0].drain && roots_due.size() != 0) begin
               // Hold off until the pipeline has emptied completely.
               start <= 1'b0;
            end else begin
               req_coef_const  <= poly_queue[0].a;
               req_coef_linear <= poly_queue[0].b;
               req_coef_square <= poly_queue[0].c;
               start           <= 1'b1;
               gap_left        = 0;
               void'(poly_queue.pop_front());
            end
         end
      end
   end

   // Monitor. The result strobe cannot be held off, so every beat is checked
   // at the edge that ends its cycle against the oldest outstanding expectation.
   always @(posedge clock) begin
      roots_type e;
      if (!reset && rsp_valid) begin
         if (roots_due.size() == 0) begin
            $error("result beat arrived with no expectation outstanding");
            errors++;
         end else begin
            e = roots_due.pop_front();
            checked_count++;
            if (e.rk == RK_TWO) two_root_count++;
            if (e.sat) sat_count++;
            if (rsp_root_kind !== e.rk) begin
               $error("root_kind: expected %0d, got %0d", e.rk, rsp_root_kind);
               errors++;
            end
            if (rsp_root_first !== e.r1) begin
               $error("root_first: expected %0d, got %0d", e.r1, rsp_root_first);
               errors++;
            end
            if (rsp_root_second !== e.r2) begin
               $error("root_second: expected %0d, got %0d", e.r2, rsp_root_second);
               errors++;
            end
            if (rsp_vertex_kind !== e.vk) begin
               $error("vertex_kind: expected %0d, got %0d", e.vk, rsp_vertex_kind);
               errors++;
            end
            if (rsp_vertex_x !== e.vx) begin
               $error("vertex_x: expected %0d, got %0d", e.vx, rsp_vertex_x);
               errors++;
            end
            if (rsp_vertex_y !== e.vy) begin
               $error("vertex_y: expected %0d, got %0d", e.vy, rsp_vertex_y);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated: expected %0d, got %0d", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog. A correct run finishes far below this cap.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int   s;
      int   t;
      int   k;
      int   mode;
      bit   burst;
      int   burst_left;
      reset      = 1'b1;
      errors     = 0;
      sent_count = 0;
      stim_done  = 0;

      // Directed polynomials: the degenerate, constant-only and linear cases,
      // negative, zero and positive discriminants, coefficient extremes and
      // quotients far outside the result range.
      queue_poly(0, 0, 0, 0, 0);
      queue_poly(1280, 0, 0, 0, 0);
      queue_poly(-32768, 0, 0, 0, 0);
      queue_poly(512, 256, 0, 0, 0);
      queue_poly(-32768, 1, 0, 0, 0);
      queue_poly(32767, -1, 0, 1, 0);
      queue_poly(0, 32767, 0, 0, 0);
      queue_poly(256, 0, 256, 0, 0);
      queue_poly(256, 512, 256, 0, 0);
      queue_poly(-256, 0, 256, 0, 0);
      queue_poly(1536, -1280, 256, 0, 0);
      queue_poly(0, 0, 1, 2, 0);
      queue_poly(0, 0, -32768, 0, 0);
      queue_poly(32767, 32767, 32767, 0, 0);
      queue_poly(-32768, -32768, -32768, 0, 0);
      queue_poly(32767, -32768, -32768, 0, 0);
      queue_poly(-32768, 32767, 1, 0, 0);
      queue_poly(32767, -32768, 1, 0, 0);
      queue_poly(0, -32768, -1, 0, 0);
      queue_poly(1, 1, 1, 0, 1);
      queue_poly(-1, -1, -1, 0, 0);
      queue_poly(32767, 0, -1, 0, 0);
      queue_poly(-32768, 0, 1, 0, 0);

      // Random polynomials. Most are full-range; the rest target small
      // coefficients, missing terms and exactly-zero discriminants.
      burst_left = 0;
      for (int i = 0; i < 1550; i++) begin
         if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
         burst = (burst_left != 0);
         if (burst_left != 0) burst_left--;
         mode = $urandom_range(0, 9);
         case (mode)
            0, 1, 2, 3: begin
               queue_poly($urandom, $urandom, $urandom, pick_gap(burst), 0);
            end
            4, 5: begin
               queue_poly($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                          $urandom_range(0, 1023) - 512, pick_gap(burst), 0);
            end
            6: begin
               queue_poly($urandom, $urandom, 0, pick_gap(burst), 0);
            end
            7: begin
               queue_poly($urandom, $urandom_range(0, 1) ? 0 : $urandom, $urandom,
                          pick_gap(burst), 0);
            end
            8: begin
               // c = k*s^2, b = 2*k*s*t, a = k*t^2 gives a zero discriminant.
               s = $urandom_range(0, 30) - 15;
               t = $urandom_range(0, 30) - 15;
               k = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1);
               queue_poly(k * t * t, 2 * k * s * t, k * s * s, pick_gap(burst), 0);
            end
            default: begin
               queue_poly($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
                          $urandom_range(0, 63) - 32, pick_gap(burst), 0);
            end
         endcase
         // Now and then the sender waits for the pipeline to drain completely.
         if ($urandom_range(0, 299) == 0) poly_queue[poly_queue.size() - 1].drain = 1;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (poly_queue.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (roots_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      $display("Sent %0d polynomials and checked %0d results.", sent_count, checked_count);
      $display("%0d had two real zeros and %0d saturated.", two_root_count, sat_count);
      if (errors == 0 && roots_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
